@@ src/jhbd_pkg.sv @@
// ----------------------------------------------------------------------------
// JPEG Huffman block decoder package
// Request and result types, mode and status codes and sizing constants
// shared by the decoder and its users.
// ----------------------------------------------------------------------------
package jhbd_pkg;

    localparam int MAX_CODE_LEN_DEF      = 16;
    localparam int BLOCK_COEFFS_DEF      = 64;
    localparam int SYMBOLS_PER_TABLE_DEF = 256;

    localparam int COUNT_DEPTH  = 64;
    localparam int SYMBOL_DEPTH = 1024;

    localparam logic [1:0] MODE_COUNT   = 2'd0;
    localparam logic [1:0] MODE_SYMBOL  = 2'd1;
    localparam logic [1:0] MODE_DATA    = 2'd2;
    localparam logic [1:0] MODE_RESTART = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_CODE = 2'd1;
    localparam logic [1:0] STATUS_BAD_SYM = 2'd2;
    localparam logic [1:0] STATUS_RUN_OVF = 2'd3;

    localparam logic [7:0] SYM_EOB = 8'h00;
    localparam logic [7:0] SYM_ZRL = 8'hF0;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] table_id;
        logic [7:0] entry_index;
        logic [7:0] entry_value;
        logic [1:0] component;
        logic       data_bit;
    } in_t;

    typedef struct packed {
        logic [5:0]        coeff_position;
        logic signed [15:0] coeff_value;
        logic [1:0]        block_component;
        logic              last;
        logic [1:0]        status;
    } out_t;

endpackage

@@ src/jpeg_huffman_block_decoder.sv @@
// ----------------------------------------------------------------------------
// JPEG Huffman block decoder
// Bit-serial baseline Huffman decoder with four canonical tables, DC
// prediction and run-length expansion of AC coefficients.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Carries
//  s_      | in        | s_valid / s_ready  | table loads, stream bits, restart
//  m_      | out       | m_valid / m_ready  | coefficients and error reports
//
// A load, a restart or a magnitude bit is handled in the idle state. A code
// bit that completes no code passes through the count memory read, then the
// canonical compare; one that completes a code adds the symbol memory read.
// Every coefficient emitted passes through the output register, so an
// end-of-block fill holds the input side until the block is filled.
// Reset is synchronous and active low; the tables keep no reset value.
// A stalled output register holds the sequencer and with it the accepting side.
module jpeg_huffman_block_decoder #(
    parameter int MAX_CODE_LEN      = jhbd_pkg::MAX_CODE_LEN_DEF,
    parameter int BLOCK_COEFFS      = jhbd_pkg::BLOCK_COEFFS_DEF,
    parameter int SYMBOLS_PER_TABLE = jhbd_pkg::SYMBOLS_PER_TABLE_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  jhbd_pkg::in_t s_item,
    output logic          m_valid,
    input  logic          m_ready,
    output jhbd_pkg::out_t m_item
);

    // The running first code is kept nine bits wider than the longest code.
    localparam int FW    = MAX_CODE_LEN + 9;
    localparam int IDX_W = $clog2(255 * MAX_CODE_LEN + 256);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_SYM  = 3'd2;
    localparam logic [2:0] ST_ZERO = 3'd3;
    localparam logic [2:0] ST_VAL  = 3'd4;
    localparam logic [2:0] ST_ERR  = 3'd5;

    localparam logic [2:0] PH_DC_CODE = 3'd0;
    localparam logic [2:0] PH_DC_MAG  = 3'd1;
    localparam logic [2:0] PH_AC_CODE = 3'd2;
    localparam logic [2:0] PH_AC_MAG  = 3'd3;
    localparam logic [2:0] PH_HALT    = 3'd4;

    localparam logic [6:0] BLK = 7'(BLOCK_COEFFS);

    // Table memories: counts per length and symbol bytes, four tables each.
    logic [7:0] count_mem [jhbd_pkg::COUNT_DEPTH];
    logic [7:0] symbol_mem [jhbd_pkg::SYMBOL_DEPTH];

    logic       cnt_we, sym_we;
    logic [5:0] cnt_waddr, cnt_raddr;
    logic [9:0] sym_waddr, sym_raddr;
    logic [7:0] cnt_q, sym_q;

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            count_mem[cnt_waddr] <= s_item.entry_value;
        end
        cnt_q <= count_mem[cnt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sym_we) begin
            symbol_mem[sym_waddr] <= s_item.entry_value;
        end
        sym_q <= symbol_mem[sym_raddr];
    end

    // Control state
    logic [2:0]     state_reg, state_next;
    logic [2:0]     phase_reg, phase_next;
    logic [15:0]    code_reg, code_next;
    logic [4:0]     len_reg, len_next;
    logic [FW-1:0]  first_reg, first_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic [1:0]     tbl_reg, tbl_next;
    logic [15:0]    mag_reg, mag_next;
    logic [3:0]     msize_reg, msize_next;
    logic [3:0]     mrem_reg, mrem_next;
    logic [3:0]     run_reg, run_next;
    logic [6:0]     pos_reg, pos_next;
    logic [1:0]     comp_reg, comp_next;
    logic [15:0]    pred_reg [3];
    logic [15:0]    pred_next [3];
    logic [15:0]    val_reg, val_next;
    logic [6:0]     zend_reg, zend_next;
    logic           zclose_reg, zclose_next;
    logic [1:0]     err_reg, err_next;
    logic           m_valid_reg;
    jhbd_pkg::out_t m_item_reg;

    logic           emit;
    jhbd_pkg::out_t emit_item;
    logic           out_free;

    // Compare datapath
    logic [FW-1:0]    code_ext, diff;
    logic             hit;
    logic [IDX_W-1:0] sym_idx;
    logic [15:0]      mag_shift, half, full, ext_val, dc_sum;
    logic [3:0]       rem_dec;
    logic [1:0]       comp_sel;
    logic [6:0]       pos_inc, pos_zrl, pos_run;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    assign code_ext = FW'(code_reg);
    assign diff     = code_ext - first_reg;
    assign hit      = (code_ext >= first_reg) && (diff < FW'(cnt_q));
    assign sym_idx  = base_reg + IDX_W'(diff);

    assign mag_shift = {mag_reg[14:0], s_item.data_bit};
    assign rem_dec   = (mrem_reg != 4'd0) ? mrem_reg - 4'd1 : 4'd0;
    assign half      = 16'd1 << (msize_reg - 4'd1);
    assign full      = (16'd1 << msize_reg) - 16'd1;
    assign ext_val   = (mag_shift < half) ? mag_shift - full : mag_shift;
    assign dc_sum    = pred_reg[comp_reg] + val_reg;
    assign comp_sel  = (s_item.component > 2'd2) ? 2'd2 : s_item.component;
    assign pos_inc   = pos_reg + 7'd1;
    assign pos_zrl   = pos_reg + 7'd16;
    assign pos_run   = pos_reg + 7'(sym_q[7:4]);

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        code_next   = code_reg;
        len_next    = len_reg;
        first_next  = first_reg;
        base_next   = base_reg;
        tbl_next    = tbl_reg;
        mag_next    = mag_reg;
        msize_next  = msize_reg;
        mrem_next   = mrem_reg;
        run_next    = run_reg;
        pos_next    = pos_reg;
        comp_next   = comp_reg;
        pred_next   = pred_reg;
        val_next    = val_reg;
        zend_next   = zend_reg;
        zclose_next = zclose_reg;
        err_next    = err_reg;
        cnt_we      = 1'b0;
        sym_we      = 1'b0;
        cnt_waddr   = {s_item.table_id, s_item.entry_index[3:0]};
        sym_waddr   = {s_item.table_id, s_item.entry_index};
        cnt_raddr   = {tbl_reg, len_reg[3:0]};
        sym_raddr   = {tbl_reg, sym_idx[7:0]};
        emit        = 1'b0;
        emit_item   = '{coeff_position: pos_reg[5:0], coeff_value: 16'sd0,
                        block_component: comp_reg, last: 1'b0,
                        status: jhbd_pkg::STATUS_OK};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_item.mode)
                        jhbd_pkg::MODE_COUNT: begin
                            cnt_we = (32'(s_item.entry_index) < MAX_CODE_LEN);
                        end
                        jhbd_pkg::MODE_SYMBOL: begin
                            sym_we = (32'(s_item.entry_index) < SYMBOLS_PER_TABLE);
                        end
                        jhbd_pkg::MODE_DATA: begin
                            if (phase_reg == PH_DC_CODE || phase_reg == PH_AC_CODE) begin
                                // Start of a block picks the component and table set.
                                if (phase_reg == PH_DC_CODE && len_reg == 5'd0) begin
                                    comp_next = comp_sel;
                                    pos_next  = 7'd0;
                                    tbl_next  = {comp_sel != 2'd0, 1'b0};
                                end else begin
                                    tbl_next = {comp_reg != 2'd0, phase_reg == PH_AC_CODE};
                                end
                                cnt_raddr  = {tbl_next, len_reg[3:0]};
                                code_next  = {code_reg[14:0], s_item.data_bit};
                                len_next   = len_reg + 5'd1;
                                state_next = ST_CMP;
                            end else if (phase_reg == PH_DC_MAG ||
                                         phase_reg == PH_AC_MAG) begin
                                mag_next  = mag_shift;
                                mrem_next = rem_dec;
                                if (rem_dec == 4'd0) begin
                                    val_next = ext_val;
                                    mag_next = 16'd0;
                                    if (phase_reg == PH_DC_MAG) begin
                                        state_next = ST_VAL;
                                    end else begin
                                        zend_next   = pos_reg + 7'(run_reg);
                                        zclose_next = 1'b0;
                                        state_next  = ST_ZERO;
                                    end
                                end
                            end
                        end
                        jhbd_pkg::MODE_RESTART: begin
                            pred_next  = '{16'd0, 16'd0, 16'd0};
                            phase_next = PH_DC_CODE;
                            code_next  = 16'd0;
                            len_next   = 5'd0;
                            first_next = '0;
                            base_next  = '0;
                            mag_next   = 16'd0;
                            msize_next = 4'd0;
                            mrem_next  = 4'd0;
                            run_next   = 4'd0;
                            pos_next   = 7'd0;
                            comp_next  = 2'd0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP: begin
                if (hit) begin
                    code_next  = 16'd0;
                    len_next   = 5'd0;
                    first_next = '0;
                    base_next  = '0;
                    if (32'(sym_idx) >= SYMBOLS_PER_TABLE) begin
                        err_next   = jhbd_pkg::STATUS_BAD_SYM;
                        state_next = ST_ERR;
                    end else begin
                        state_next = ST_SYM;
                    end
                end else begin
                    base_next  = base_reg + IDX_W'(cnt_q);
                    first_next = (first_reg + FW'(cnt_q)) << 1;
                    if (32'(len_reg) >= MAX_CODE_LEN) begin
                        err_next   = jhbd_pkg::STATUS_NO_CODE;
                        state_next = ST_ERR;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SYM: begin
                state_next = ST_IDLE;
                if (!tbl_reg[0]) begin
                    if (sym_q > 8'd11) begin
                        err_next   = jhbd_pkg::STATUS_BAD_SYM;
                        state_next = ST_ERR;
                    end else if (sym_q == 8'd0) begin
                        val_next   = 16'd0;
                        state_next = ST_VAL;
                    end else begin
                        msize_next = sym_q[3:0];
                        mrem_next  = sym_q[3:0];
                        mag_next   = 16'd0;
                        phase_next = PH_DC_MAG;
                    end
                end else if (sym_q == jhbd_pkg::SYM_EOB) begin
                    zend_next   = BLK;
                    zclose_next = 1'b1;
                    state_next  = ST_ZERO;
                end else if (sym_q == jhbd_pkg::SYM_ZRL) begin
                    if (pos_zrl > BLK) begin
                        err_next   = jhbd_pkg::STATUS_RUN_OVF;
                        state_next = ST_ERR;
                    end else begin
                        zend_next   = pos_zrl;
                        zclose_next = (pos_zrl == BLK);
                        state_next  = ST_ZERO;
                    end
                end else if (sym_q[3:0] == 4'd0 || sym_q[3:0] > 4'd10) begin
                    err_next   = jhbd_pkg::STATUS_BAD_SYM;
                    state_next = ST_ERR;
                end else if (pos_run >= BLK) begin
                    err_next   = jhbd_pkg::STATUS_RUN_OVF;
                    state_next = ST_ERR;
                end else begin
                    run_next   = sym_q[7:4];
                    msize_next = sym_q[3:0];
                    mrem_next  = sym_q[3:0];
                    mag_next   = 16'd0;
                    phase_next = PH_AC_MAG;
                end
            end
            ST_ZERO: begin
                if (pos_reg < zend_reg) begin
                    if (out_free) begin
                        emit           = 1'b1;
                        emit_item.last = zclose_reg && (pos_inc == zend_reg);
                        pos_next       = pos_inc;
                    end
                end else if (phase_reg == PH_AC_MAG) begin
                    state_next = ST_VAL;
                end else begin
                    if (pos_reg >= BLK) begin
                        pos_next   = 7'd0;
                        phase_next = PH_DC_CODE;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_VAL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    msize_next = 4'd0;
                    phase_next = PH_AC_CODE;
                    if (phase_reg == PH_AC_MAG) begin
                        emit_item.coeff_value = val_reg;
                        emit_item.last        = (pos_inc == BLK);
                        run_next              = 4'd0;
                        if (pos_inc >= BLK) begin
                            pos_next   = 7'd0;
                            phase_next = PH_DC_CODE;
                        end else begin
                            pos_next = pos_inc;
                        end
                    end else begin
                        // DC coefficient: predictor plus difference, 16-bit wrap.
                        emit_item.coeff_position = 6'd0;
                        emit_item.coeff_value    = dc_sum;
                        pred_next[comp_reg]      = dc_sum;
                        pos_next                 = 7'd1;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    emit             = 1'b1;
                    emit_item.last   = 1'b1;
                    emit_item.status = err_reg;
                    phase_next       = PH_HALT;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_DC_CODE;
            code_reg    <= 16'd0;
            len_reg     <= 5'd0;
            first_reg   <= '0;
            base_reg    <= '0;
            mag_reg     <= 16'd0;
            msize_reg   <= 4'd0;
            mrem_reg    <= 4'd0;
            run_reg     <= 4'd0;
            pos_reg     <= 7'd0;
            comp_reg    <= 2'd0;
            pred_reg    <= '{16'd0, 16'd0, 16'd0};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            code_reg  <= code_next;
            len_reg   <= len_next;
            first_reg <= first_next;
            base_reg  <= base_next;
            mag_reg   <= mag_next;
            msize_reg <= msize_next;
            mrem_reg  <= mrem_next;
            run_reg   <= run_next;
            pos_reg   <= pos_next;
            comp_reg  <= comp_next;
            pred_reg  <= pred_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and scratch registers carry no reset.
    always_ff @(posedge aclk) begin
        tbl_reg    <= tbl_next;
        val_reg    <= val_next;
        zend_reg   <= zend_next;
        zclose_reg <= zclose_next;
        err_reg    <= err_next;
        if (emit) begin
            m_item_reg <= emit_item;
        end
    end

`ifndef SYNTHESIS
    // An error report always closes the block.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != jhbd_pkg::STATUS_OK |-> m_item.last)
        else $error("error result without last");

    // The block position never runs past the block.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= BLK)
        else $error("block position beyond block");

    // Once an error is reported the decoder halts.
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && emit_item.status != jhbd_pkg::STATUS_OK |=> phase_reg == PH_HALT)
        else $error("decoder did not halt after error");

    // Input is taken only with no coefficients left to produce.
    a_idle_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !emit)
        else $error("input accepted while emitting");
`endif

endmodule
